### src/wspp_pkg.sv
// Package: sizes, codes and sequencer states of the shortest-path planner.
`default_nettype none
package wspp_pkg;
    localparam int NODES      = 16;
    localparam int MAX_DEGREE = 4;
    localparam int MAX_GOALS  = 4;
    localparam int NODE_W     = $clog2(NODES);
    localparam int DEG_W      = $clog2(MAX_DEGREE);
    localparam int GOAL_W     = $clog2(MAX_GOALS);
    localparam int DIST_W     = 16;
    localparam logic [DIST_W-1:0] INF_DIST = '1;

    typedef enum logic [1:0] {
        MODE_EDGE  = 2'd0,
        MODE_MARKS = 2'd1,
        MODE_GOAL  = 2'd2,
        MODE_RUN   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_AR    = 2'd0,
        CFG_MR    = 2'd1,
        CFG_FAKE  = 2'd2,
        CFG_PLAIN = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_PICK,
        ST_RELAX,
        ST_GOAL,
        ST_GOALDONE,
        ST_TRACE,
        ST_EMIT
    } state_t;
endpackage
`default_nettype wire

### src/weighted_shortest_path_planner.sv
// Top level: Dijkstra shortest-path planner with a single shared compare/add unit.
`default_nettype none
// A beat on start/mode/node/... is taken when start is high and busy is low.
// Load beats (modes 0..2) give no result. A run beat keeps busy high while
// a small sequencer drives one shared adder/comparator: it clears the
// tables, then per settled node scans all nodes for the minimum, picks it
// and relaxes each adjacency slot, then runs a last scan and pick that find
// nothing, a check of each goal slot, a decision, a predecessor walk over
// the path nodes and the emission of the results. Results appear one
// per cycle on path_node, total_cost, reachable and last, marked by
// out_valid; the receiver cannot stall them, so each result is shown for
// exactly one cycle. Configuration writes (weights) are always ready and
// should be issued while idle.
module weighted_shortest_path_planner (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    mode,
    input  wire logic [3:0]                    node,
    input  wire logic [1:0]                    slot,
    input  wire logic [3:0]                    neighbour,
    input  wire logic                          enable,
    input  wire logic [2:0]                    marks,
    output logic                               out_valid,
    output logic [3:0]                         path_node,
    output logic [15:0]                        total_cost,
    output logic                               reachable,
    output logic                               last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [7:0]                    cfg_data
);
    import wspp_pkg::*;

    // configuration weights
    logic [7:0] w_ar_reg, w_mr_reg, w_fake_reg, w_plain_reg;

    // graph stores
    logic [NODES*MAX_DEGREE-1:0]    adj_vld_reg;
    logic [NODE_W-1:0]              adj_dst_reg [NODES*MAX_DEGREE];
    logic [2:0]                     marks_reg   [NODES];
    logic [MAX_GOALS-1:0]           goal_vld_reg;
    logic [NODE_W-1:0]              goal_node_reg [MAX_GOALS];

    // search tables
    logic [DIST_W-1:0]  dist_reg [NODES];
    logic [NODE_W-1:0]  pred_reg [NODES];
    logic [NODES-1:0]   pred_vld_reg;
    logic [NODES-1:0]   settled_reg;
    logic [NODE_W-1:0]  trail_reg [NODES];

    state_t             state_reg, state_next;
    logic [NODE_W:0]    idx_reg;          // scan / init counter
    logic [DEG_W:0]     deg_reg;
    logic [GOAL_W:0]    gidx_reg;
    logic [NODE_W-1:0]  start_reg;
    logic [NODE_W-1:0]  u_reg;            // current best / settling node
    logic               u_found_reg;
    logic [NODE_W-1:0]  best_reg;
    logic               best_found_reg;
    logic [NODE_W:0]    count_reg;        // trail length
    logic [NODE_W-1:0]  cur_reg;
    logic [NODE_W-1:0]  adj_rd_reg;       // registered adjacency slot read

    logic               accept;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // shared arithmetic unit: one add and one compare per cycle
    logic [DIST_W-1:0]  alu_a, alu_b;
    logic [DIST_W-1:0]  alu_sum;
    logic               alu_lt;

    // ---------------- next state ----------------
    logic [NODE_W-1:0]  ii;
    logic [DEG_W-1:0]   dd;
    logic [GOAL_W-1:0]  gg;
    logic [NODE_W+DEG_W-1:0] eidx;
    logic [NODE_W+DEG_W-1:0] adj_raddr;
    logic [NODE_W-1:0]  vdst;
    logic [7:0]         wsel;
    assign ii   = idx_reg[NODE_W-1:0];
    assign dd   = deg_reg[DEG_W-1:0];
    assign gg   = gidx_reg[GOAL_W-1:0];
    assign eidx = {u_reg, dd};
    // fetch each slot in the cycle before it is used: slot 0 during pick, the next one while relaxing
    assign adj_raddr = {u_reg, (state_reg == ST_RELAX) ? dd + DEG_W'(1) : DEG_W'(0)};
    assign vdst = adj_rd_reg;

    always_comb
    begin
        wsel = w_plain_reg;
        if (marks_reg[vdst][0])      wsel = w_ar_reg;
        else if (marks_reg[vdst][1]) wsel = w_mr_reg;
        else if (marks_reg[vdst][2]) wsel = w_fake_reg;
    end

    always_comb
    begin
        alu_sum = dist_reg[u_reg] + DIST_W'(wsel);
        alu_a = dist_reg[ii];
        alu_b = dist_reg[u_reg];
        case (state_reg)
            ST_RELAX:
            begin
                alu_a = alu_sum;
                alu_b = dist_reg[vdst];
            end
            ST_GOAL:
            begin
                alu_a = dist_reg[goal_node_reg[gg]];
                alu_b = dist_reg[best_reg];
            end
            default: ;
        endcase
        alu_lt  = alu_a < alu_b;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && mode_t'(mode) == MODE_RUN) state_next = ST_INIT;
            ST_INIT:
                if (idx_reg == (NODE_W+1)'(NODES-1)) state_next = ST_SCAN;
            ST_SCAN:
                if (idx_reg == (NODE_W+1)'(NODES-1)) state_next = ST_PICK;
            ST_PICK:
                state_next = u_found_reg ? ST_RELAX : ST_GOAL;
            ST_RELAX:
                if (deg_reg == (DEG_W+1)'(MAX_DEGREE-1)) state_next = ST_SCAN;
            ST_GOAL:
                if (gidx_reg == (GOAL_W+1)'(MAX_GOALS-1)) state_next = ST_GOALDONE;
            ST_GOALDONE:
                if (!best_found_reg || dist_reg[best_reg] == INF_DIST)
                    state_next = ST_EMIT;
                else
                    state_next = ST_TRACE;
            ST_TRACE:
                if (cur_reg == start_reg || !pred_vld_reg[cur_reg]
                    || count_reg == (NODE_W+1)'(NODES-1))
                    state_next = ST_EMIT;
            ST_EMIT:
                if (count_reg <= (NODE_W+1)'(1)) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------- outputs ----------------
    logic emit_single;
    assign emit_single = !best_found_reg || dist_reg[best_reg] == INF_DIST;

    always_comb
    begin
        busy       = (state_reg != ST_IDLE);
        out_valid  = 1'b0;
        path_node  = '0;
        total_cost = INF_DIST;
        reachable  = 1'b0;
        last       = 1'b0;
        case (state_reg)
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (emit_single)
                begin
                    path_node = best_found_reg ? best_reg : start_reg;
                    last      = 1'b1;
                end
                else
                begin
                    path_node  = trail_reg[count_reg[NODE_W-1:0] - NODE_W'(1)];
                    total_cost = dist_reg[best_reg];
                    reachable  = 1'b1;
                    last       = (count_reg == (NODE_W+1)'(1));
                end
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            deg_reg        <= '0;
            gidx_reg       <= '0;
            u_found_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            count_reg      <= '0;
            w_ar_reg       <= 8'd50;
            w_mr_reg       <= 8'd20;
            w_fake_reg     <= 8'd100;
            w_plain_reg    <= 8'd1;
            adj_vld_reg    <= '0;
            goal_vld_reg   <= '0;
            for (int n = 0; n < NODES; n++) marks_reg[n] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_AR:    w_ar_reg    <= cfg_data;
                    CFG_MR:    w_mr_reg    <= cfg_data;
                    CFG_FAKE:  w_fake_reg  <= cfg_data;
                    CFG_PLAIN: w_plain_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                case (mode_t'(mode))
                    MODE_EDGE:  adj_vld_reg[{node, slot}] <= enable;
                    MODE_MARKS: marks_reg[node] <= marks;
                    MODE_GOAL:  goal_vld_reg[slot] <= enable;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg        <= '0;
                    u_found_reg    <= 1'b0;
                    best_found_reg <= 1'b0;
                end
                ST_INIT, ST_SCAN:
                begin
                    idx_reg <= (idx_reg == (NODE_W+1)'(NODES-1)) ? '0
                               : idx_reg + (NODE_W+1)'(1);
                    if (state_reg == ST_SCAN && !settled_reg[ii]
                        && dist_reg[ii] != INF_DIST
                        && (!u_found_reg || alu_lt))
                        u_found_reg <= 1'b1;
                    deg_reg <= '0;
                end
                ST_PICK:
                begin
                    gidx_reg <= '0;
                end
                ST_RELAX:
                begin
                    deg_reg <= deg_reg + (DEG_W+1)'(1);
                    if (deg_reg == (DEG_W+1)'(MAX_DEGREE-1)) u_found_reg <= 1'b0;
                end
                ST_GOAL:
                begin
                    gidx_reg <= gidx_reg + (GOAL_W+1)'(1);
                    if (goal_vld_reg[gg] && (!best_found_reg || alu_lt))
                        best_found_reg <= 1'b1;
                    count_reg <= '0;
                end
                ST_GOALDONE:
                    count_reg <= emit_single ? (NODE_W+1)'(1) : '0;
                ST_TRACE:
                    count_reg <= count_reg + (NODE_W+1)'(1);
                ST_EMIT:
                    count_reg <= count_reg - (NODE_W+1)'(1);
                default: ;
            endcase
        end
    end

    // ---------------- data registers ----------------
    always_ff @(posedge clk)
    begin
        adj_rd_reg <= adj_dst_reg[adj_raddr];
        if (accept)
        begin
            case (mode_t'(mode))
                MODE_EDGE: adj_dst_reg[{node, slot}] <= neighbour;
                MODE_GOAL: goal_node_reg[slot] <= node;
                MODE_RUN:  start_reg <= node;
                default: ;
            endcase
        end
        case (state_reg)
            ST_INIT:
            begin
                dist_reg[ii]     <= (ii == start_reg) ? '0 : INF_DIST;
                pred_vld_reg[ii] <= 1'b0;
                settled_reg[ii]  <= 1'b0;
            end
            ST_SCAN:
                if (!settled_reg[ii] && dist_reg[ii] != INF_DIST
                    && (!u_found_reg || alu_lt))
                    u_reg <= ii;
            ST_PICK:
                if (u_found_reg) settled_reg[u_reg] <= 1'b1;
            ST_RELAX:
                if (adj_vld_reg[eidx] && alu_lt)
                begin
                    dist_reg[vdst]     <= alu_sum;
                    pred_reg[vdst]     <= u_reg;
                    pred_vld_reg[vdst] <= 1'b1;
                end
            ST_GOAL:
                if (goal_vld_reg[gg] && (!best_found_reg || alu_lt))
                    best_reg <= goal_node_reg[gg];
            ST_GOALDONE:
                cur_reg <= best_reg;
            ST_TRACE:
            begin
                trail_reg[count_reg[NODE_W-1:0]] <= cur_reg;
                cur_reg <= pred_reg[cur_reg];
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("result strobe while idle");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |=> !out_valid)
        else $error("result after last");
    a_reach_cost: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !reachable) |-> (total_cost == INF_DIST && last))
        else $error("unreachable result malformed");
    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_RUN) |=> busy)
        else $error("run not started");
`endif

endmodule
`default_nettype wire

### test/tb_top.sv
// Testbench for the weighted shortest-path planner: random graphs, scoreboarded paths.
`default_nettype none
module tb_top;
    import wspp_pkg::*;

    // One path beat as the block shows it on its result ports.
    typedef struct packed {
        logic [3:0]  node;
        logic [15:0] cost;
        logic        reach;
        logic        fin;
    } path_beat_t;

    // Scoreboard: a private copy of the planner's tables and weights. Each
    // accepted run beat is turned into the path beats it should produce.
    class path_scoreboard;
        logic [7:0]  weight [4];
        logic [4:0]  adj [NODES*MAX_DEGREE];
        logic [2:0]  flags [NODES];
        logic [4:0]  goals [MAX_GOALS];
        path_beat_t  pending [$];
        int          errors;

        function new();
            weight[CFG_AR]    = 8'd50;
            weight[CFG_MR]    = 8'd20;
            weight[CFG_FAKE]  = 8'd100;
            weight[CFG_PLAIN] = 8'd1;
            foreach (adj[i]) adj[i] = '0;
            foreach (flags[i]) flags[i] = '0;
            foreach (goals[i]) goals[i] = '0;
            errors = 0;
        endfunction

        function void set_weight(cfg_idx_t idx, logic [7:0] value);
            weight[idx] = value;
        endfunction

        // Cost of entering node v: ar beats mr beats fake beats plain.
        function int entry_cost(int v);
            if (flags[v][0]) return weight[CFG_AR];
            if (flags[v][1]) return weight[CFG_MR];
            if (flags[v][2]) return weight[CFG_FAKE];
            return weight[CFG_PLAIN];
        endfunction

        function void plan_route(logic [3:0] origin);
            int  dist_tab [NODES];
            int  prev [NODES];
            bit  done [NODES];
            int  trail [$];
            int  u, v, nd, pick, target, cur;
            for (int i = 0; i < NODES; i++) begin
                dist_tab[i] = INF_DIST;
                prev[i] = -1;
                done[i] = 0;
            end
            dist_tab[origin] = 0;
            for (int it = 0; it < NODES; it++) begin
                u = -1;
                // lowest id wins a tie
                for (int i = 0; i < NODES; i++)
                    if (!done[i] && dist_tab[i] != INF_DIST
                        && (u < 0 || dist_tab[i] < dist_tab[u]))
                        u = i;
                if (u < 0) break;
                done[u] = 1;
                for (int k = 0; k < MAX_DEGREE; k++) begin
                    if (!adj[u*MAX_DEGREE+k][4]) continue;
                    v = adj[u*MAX_DEGREE+k][3:0];
                    nd = dist_tab[u] + entry_cost(v);
                    if (nd < dist_tab[v]) begin
                        dist_tab[v] = nd;
                        prev[v] = u;
                    end
                end
            end
            pick = -1;
            target = 0;
            for (int g = 0; g < MAX_GOALS; g++) begin
                if (!goals[g][4]) continue;
                if (pick < 0 || dist_tab[goals[g][3:0]] < dist_tab[target]) begin
                    pick = g;
                    target = goals[g][3:0];
                end
            end
            if (pick < 0) begin
                pending.push_back({origin, INF_DIST, 1'b0, 1'b1});
                return;
            end
            if (dist_tab[target] == INF_DIST) begin
                pending.push_back({4'(target), INF_DIST, 1'b0, 1'b1});
                return;
            end
            cur = target;
            while (trail.size() < NODES) begin
                trail.push_front(cur);
                if (cur == origin || prev[cur] < 0) break;
                cur = prev[cur];
            end
            foreach (trail[i])
                pending.push_back({4'(trail[i]), 16'(dist_tab[target]), 1'b1,
                                   1'(i == trail.size() - 1)});
        endfunction

        function void note_beat(mode_t m, logic [3:0] nd, logic [1:0] sl, logic [3:0] nb,
                                logic en, logic [2:0] mk);
            case (m)
                MODE_EDGE:  adj[nd*MAX_DEGREE+sl] = en ? {1'b1, nb} : 5'd0;
                MODE_MARKS: flags[nd] = mk;
                MODE_GOAL:  goals[sl] = en ? {1'b1, nd} : 5'd0;
                MODE_RUN:   plan_route(nd);
                default: ;
            endcase
        endfunction

        function void check_beat(path_beat_t got);
            path_beat_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected path beat %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.node !== want.node)
                $display("%0t: path_node expected %0d actual %0d", $time, want.node, got.node);
            if (got.cost !== want.cost)
                $display("%0t: total_cost expected %0d actual %0d", $time, want.cost, got.cost);
            if (got.reach !== want.reach)
                $display("%0t: reachable expected %b actual %b", $time, want.reach, got.reach);
            if (got.fin !== want.fin)
                $display("%0t: last expected %b actual %b", $time, want.fin, got.fin);
            if (got !== want) errors++;
        endfunction
    endclass

    logic       clk = 0;
    logic       rst_n = 0;
    logic       start = 0;
    logic [1:0] mode = '0;
    logic [3:0] node = '0;
    logic [1:0] slot = '0;
    logic [3:0] neighbour = '0;
    logic       enable = 0;
    logic [2:0] marks = '0;
    logic       cfg_valid = 0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       busy, out_valid, reachable, last, cfg_ready;
    logic [3:0] path_node;
    logic [15:0] total_cost;

    path_scoreboard sb = new();
    int unsigned cycles = 0;

    weighted_shortest_path_planner uut (.*);

    always #1 clk = ~clk;

    // Watch the command, configuration and result channels at every edge; all reads see pre-edge values.
    always @(posedge clk) begin
        if (rst_n && start && !busy)
            sb.note_beat(mode_t'(mode), node, slot, neighbour, enable, marks);
        if (rst_n && cfg_valid && cfg_ready)
            sb.set_weight(cfg_idx_t'(cfg_index), cfg_data);
        if (rst_n && out_valid)
            sb.check_beat({path_node, total_cost, reachable, last});
    end

    // Hard stop well past the slowest legal run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == 1000000) begin
            $display("status: fail");
            $finish;
        end
    end

    // Mostly back-to-back, sometimes a short pause, rarely a long one.
    function int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // Drive one command beat and hold it until the block takes it.
    task automatic send(mode_t m, logic [3:0] nd, logic [1:0] sl, logic [3:0] nb,
                        logic en, logic [2:0] mk);
        int gap;
        start     <= 1'b1;
        mode      <= m;
        node      <= nd;
        slot      <= sl;
        neighbour <= nb;
        enable    <= en;
        marks     <= mk;
        do @(posedge clk); while (busy);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain all expected beats, then let any trailing load settle.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_weight(cfg_idx_t idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_beat();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            send(MODE_EDGE, 4'($urandom), 2'($urandom), 4'($urandom),
                 ($urandom_range(9) != 0), '0);
        else if (r < 55)
            send(MODE_MARKS, 4'($urandom), '0, '0, 1'b0, 3'($urandom));
        else if (r < 68)
            send(MODE_GOAL, 4'($urandom), 2'($urandom), '0, ($urandom_range(4) != 0), '0);
        else
            send(MODE_RUN, 4'($urandom), '0, '0, 1'b0, '0);
    endtask

    initial begin
        logic [7:0] w [4];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: no goal at all, then a short weighted graph.
        send(MODE_RUN, 4'd0, '0, '0, 1'b0, '0);
        send(MODE_EDGE, 4'd0, 2'd0, 4'd1, 1'b1, '0);
        send(MODE_EDGE, 4'd1, 2'd1, 4'd2, 1'b1, '0);
        send(MODE_EDGE, 4'd2, 2'd3, 4'd3, 1'b1, '0);
        send(MODE_EDGE, 4'd0, 2'd3, 4'd3, 1'b1, '0);
        send(MODE_EDGE, 4'd3, 2'd2, 4'd15, 1'b1, '0);
        send(MODE_MARKS, 4'd1, '0, '0, 1'b0, 3'b010);
        send(MODE_MARKS, 4'd2, '0, '0, 1'b0, 3'b100);
        send(MODE_MARKS, 4'd3, '0, '0, 1'b0, 3'b111);
        send(MODE_GOAL, 4'd5, 2'd0, '0, 1'b1, '0);
        send(MODE_GOAL, 4'd15, 2'd3, '0, 1'b1, '0);
        send(MODE_RUN, 4'd0, '0, '0, 1'b0, '0);    // reaches 15 via 3
        send(MODE_RUN, 4'd5, '0, '0, 1'b0, '0);    // start is its own goal
        send(MODE_RUN, 4'd15, '0, '0, 1'b0, '0);   // start is goal 15; goal 5 unreachable
        send(MODE_EDGE, 4'd0, 2'd3, 4'd3, 1'b0, '0);
        send(MODE_MARKS, 4'd3, '0, '0, 1'b0, 3'b000);
        send(MODE_GOAL, 4'd5, 2'd0, '0, 1'b0, '0);
        send(MODE_RUN, 4'd0, '0, '0, 1'b0, '0);    // long way round now
        send(MODE_GOAL, 4'd15, 2'd3, '0, 1'b0, '0);
        send(MODE_RUN, 4'd0, '0, '0, 1'b0, '0);
        drain();

        // Random: weight sets from zero through full scale, graph keeps evolving.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: w = '{8'd0, 8'd0, 8'd0, 8'd0};
                1: w = '{8'd255, 8'd255, 8'd255, 8'd255};
                2: w = '{8'd255, 8'd0, 8'd128, 8'd1};
                default: foreach (w[i]) w[i] = 8'($urandom);
            endcase
            write_weight(CFG_AR, w[0]);
            write_weight(CFG_MR, w[1]);
            write_weight(CFG_FAKE, w[2]);
            write_weight(CFG_PLAIN, w[3]);
            for (int n = 0; n < 30; n++) random_beat();
            drain();
        end

        if (sb.pending.size() != 0) begin
            $display("%0t: %0d path beats never arrived", $time, sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
